### rtl/rgbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbb_pkg;

  // default sizes of the sine lookup and of the step counter
  localparam int DEF_SINE_ENTRIES = 256;
  localparam int DEF_STEP_BITS    = 16;

  // effect modes
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_MONO    = 2'd1;
  localparam logic [1:0] MODE_RAINBOW = 2'd2;

  // request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // configuration values seen by the engine
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] period;
    logic [7:0]  tgt_red;
    logic [7:0]  tgt_green;
    logic [7:0]  tgt_blue;
  } cfg_t;

  // one request handed to the engine
  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } req_t;

  // held colour and lit flag after a request
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;
  } res_t;

endpackage

`default_nettype wire

### rtl/rgbb_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbb_engine #(
  parameter int SINE_ENTRIES = rgbb_pkg::DEF_SINE_ENTRIES,
  parameter int STEP_BITS    = rgbb_pkg::DEF_STEP_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rgbb_pkg::cfg_t cfg_i,
  input  wire logic          step_clr_i,
  input  wire logic          start_i,
  input  wire rgbb_pkg::req_t req_i,
  output logic               idle_o,
  input  wire logic          res_free_i,
  output logic               done_o,
  output rgbb_pkg::res_t     res_o
);

  // sine entries are a power of two; phase has two more bits for the quarter
  localparam int SB   = $clog2(SINE_ENTRIES);
  localparam int PB   = SB + 2;
  localparam int CW   = ((STEP_BITS > 16) ? STEP_BITS : 16) + 1;
  localparam int DW   = 19;
  localparam int CNTW = 5;
  localparam logic [CNTW-1:0] PHASE_ITERS = CNTW'(PB);
  localparam logic [CNTW-1:0] HUE_ITERS   = CNTW'(DW);

  // odd polynomial coefficients of the quarter sine, Q30
  localparam logic [31:0] Q30_C1 = 32'd1686629713;
  localparam logic [31:0] Q30_C3 = 32'd693598668;
  localparam logic [31:0] Q30_C5 = 32'd85569306;
  localparam logic [31:0] Q30_C7 = 32'd5026995;
  localparam logic [31:0] Q30_C9 = 32'd172272;

  localparam logic [16:0] MAG_FULL  = 17'h10000;
  localparam logic [17:0] BQ_BIAS   = 18'h10000;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_PH,
    ST_PHASE,
    ST_SQ,
    ST_HORN,
    ST_ODD,
    ST_BRIGHT,
    ST_MONO,
    ST_DIV_HUE,
    ST_RC,
    ST_RX,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [STEP_BITS-1:0] step_r;
  logic [7:0]           red_r, green_r, blue_r;
  logic                 on_r;
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        div_d_r;
  logic [DW-1:0]        quo_r;
  logic [CNTW-1:0]      cnt_r;
  logic [29:0]          x_r;
  logic [29:0]          x2_r;
  logic [31:0]          t_r;
  logic [16:0]          mag_r;
  logic [16:0]          bq_r;
  logic [23:0]          c255_r;

  // step advance, wrapping at the period (zero period counts as one)
  logic [15:0]          period_eff;
  logic [CW-1:0]        step_inc;
  logic [STEP_BITS-1:0] step_nxt;
  logic                 breathing;

  assign period_eff = (cfg_i.period == 16'd0) ? 16'd1 : cfg_i.period;
  assign step_inc   = CW'(step_r) + CW'(1);
  assign step_nxt   = (step_inc == CW'(period_eff)) ? '0 : step_inc[STEP_BITS-1:0];
  assign breathing  = (cfg_i.mode == rgbb_pkg::MODE_MONO) ||
                      (cfg_i.mode == rgbb_pkg::MODE_RAINBOW);

  // shared restoring divider step: one quotient bit per cycle
  logic [DW:0]   rem2, dsub, div_rem;
  logic          div_ge;

  assign rem2    = {rem_r, 1'b0};
  assign dsub    = {1'b0, div_d_r};
  assign div_ge  = rem2 >= dsub;
  assign div_rem = div_ge ? (rem2 - dsub) : rem2;

  // phase split into quarter and table offset, mirrored in odd quarters
  logic [1:0]  quarter;
  logic [SB:0] sine_j;

  assign quarter = quo_r[PB-1:SB];
  assign sine_j  = quarter[0] ? ((SB+1)'(SINE_ENTRIES) - {1'b0, quo_r[SB-1:0]})
                              : {1'b0, quo_r[SB-1:0]};

  // shared multiplier with operand selection by state
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [7:0]  mono_tgt;
  logic [16:0] hue_w;
  logic [2:0]  sector;

  assign sector = quo_r[18:16];
  assign hue_w  = sector[0] ? (MAG_FULL - {1'b0, quo_r[15:0]}) : {1'b0, quo_r[15:0]};

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    mono_tgt = cfg_i.tgt_red;
      2'd1:    mono_tgt = cfg_i.tgt_green;
      default: mono_tgt = cfg_i.tgt_blue;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_SQ: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      ST_HORN: begin
        mul_a = 32'(x2_r);
        mul_b = t_r;
      end
      ST_ODD: begin
        mul_a = 32'(x_r);
        mul_b = t_r;
      end
      ST_MONO: begin
        mul_a = 32'(mono_tgt);
        mul_b = 32'(bq_r);
      end
      ST_RC: begin
        mul_a = 32'(bq_r);
        mul_b = 32'(LEVEL_MAX);
      end
      ST_RX: begin
        mul_a = 32'(c255_r);
        mul_b = 32'(hue_w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // horner coefficient for the current step
  logic [31:0] horn_coef;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd3:    horn_coef = Q30_C7;
      2'd2:    horn_coef = Q30_C5;
      2'd1:    horn_coef = Q30_C3;
      default: horn_coef = Q30_C1;
    endcase
  end

  // final odd term, rounding to Q16 and saturating
  logic [32:0] v_raw;
  logic [18:0] v_q16;
  logic [15:0] v_sat;

  assign v_raw = {1'b0, mul_p[61:30]} + 33'd8192;
  assign v_q16 = v_raw[32:14];
  assign v_sat = (|v_q16[18:16]) ? 16'hFFFF : v_q16[15:0];

  // brightness (sin + 1) / 2 in Q16
  logic [17:0] bsum;
  logic [16:0] bq_val;

  assign bsum   = quarter[1] ? (BQ_BIAS - 18'(mag_r)) : (BQ_BIAS + 18'(mag_r));
  assign bq_val = bsum[17:1];

  // rainbow chroma and ramp levels
  logic [7:0] hue_c, hue_x;

  assign hue_c = c255_r[23:16];
  assign hue_x = mul_p[39:32];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      on_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start_i) begin
            if (req_i.kind == rgbb_pkg::REQ_SET) begin
              red_r   <= req_i.red;
              green_r <= req_i.green;
              blue_r  <= req_i.blue;
              on_r    <= |{req_i.red, req_i.green, req_i.blue};
              state_r <= ST_DONE;
            end else if (breathing) begin
              step_r  <= step_nxt;
              rem_r   <= DW'(16'(step_nxt));
              div_d_r <= DW'(period_eff);
              cnt_r   <= PHASE_ITERS;
              state_r <= ST_DIV_PH;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DIV_PH: begin
          rem_r <= div_rem[DW-1:0];
          quo_r <= {quo_r[DW-2:0], div_ge};
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          // the peak of the wave needs no polynomial
          if (sine_j[SB]) begin
            mag_r   <= MAG_FULL;
            state_r <= ST_BRIGHT;
          end else begin
            x_r     <= 30'(sine_j[SB-1:0]) << (30 - SB);
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          x2_r    <= mul_p[59:30];
          t_r     <= Q30_C9;
          cnt_r   <= CNTW'(3);
          state_r <= ST_HORN;
        end
        ST_HORN: begin
          t_r <= horn_coef - mul_p[61:30];
          if (cnt_r == '0) begin
            state_r <= ST_ODD;
          end else begin
            cnt_r <= cnt_r - CNTW'(1);
          end
        end
        ST_ODD: begin
          mag_r   <= {1'b0, v_sat};
          state_r <= ST_BRIGHT;
        end
        ST_BRIGHT: begin
          bq_r <= bq_val;
          if (cfg_i.mode == rgbb_pkg::MODE_MONO) begin
            cnt_r   <= '0;
            state_r <= ST_MONO;
          end else begin
            rem_r   <= DW'(16'(step_r)) * DW'(6);
            div_d_r <= {period_eff, 3'b000};
            cnt_r   <= HUE_ITERS;
            state_r <= ST_DIV_HUE;
          end
        end
        ST_MONO: begin
          unique case (cnt_r[1:0])
            2'd0:    red_r   <= mul_p[23:16];
            2'd1:    green_r <= mul_p[23:16];
            default: blue_r  <= mul_p[23:16];
          endcase
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(2)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DIV_HUE: begin
          rem_r <= div_rem[DW-1:0];
          quo_r <= {quo_r[DW-2:0], div_ge};
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= ST_RC;
          end
        end
        ST_RC: begin
          c255_r  <= mul_p[23:0];
          state_r <= ST_RX;
        end
        ST_RX: begin
          unique case (sector)
            3'd0: begin
              red_r <= hue_c; green_r <= hue_x; blue_r <= '0;
            end
            3'd1: begin
              red_r <= hue_x; green_r <= hue_c; blue_r <= '0;
            end
            3'd2: begin
              red_r <= '0; green_r <= hue_c; blue_r <= hue_x;
            end
            3'd3: begin
              red_r <= '0; green_r <= hue_x; blue_r <= hue_c;
            end
            3'd4: begin
              red_r <= hue_x; green_r <= '0; blue_r <= hue_c;
            end
            default: begin
              red_r <= hue_c; green_r <= '0; blue_r <= hue_x;
            end
          endcase
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free_i) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // a period write restarts the breathing cycle
      if (step_clr_i) begin
        step_r <= '0;
      end
    end
  end

  assign idle_o    = (state_r == ST_IDLE);
  assign done_o    = (state_r == ST_DONE) && res_free_i;
  assign res_o.red   = red_r;
  assign res_o.green = green_r;
  assign res_o.blue  = blue_r;
  assign res_o.lit   = on_r;

endmodule

`default_nettype wire

### rtl/rgb_breathing_led_driver.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                | contents
// ---------+--------------------------------------+---------------------------------
// in       | in_tvalid/in_tready/in_tdata/in_tuser | request: kind, colour to hold
// out      | out_tvalid/out_tready/out_tdata       | three duties, held colour, lit
// cfg      | cfg_psel/penable/pwrite/paddr/...     | six registers at 4-byte steps
//
// a set-colour request or a tick in static mode skips the arithmetic; a mono or
// rainbow tick runs through the bit-serial divider and the single shared
// multiplier, and a rainbow tick runs the divider a second time for the hue.
// in_tready is high only while the engine is idle; a finished result waits in
// the output register and the engine holds until that register is free.
// rst_n is synchronous; registers come back to their listed reset values.

module rgb_breathing_led_driver #(
  parameter int SINE_ENTRIES = rgbb_pkg::DEF_SINE_ENTRIES,
  parameter int STEP_BITS    = rgbb_pkg::DEF_STEP_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // set_red, set_green, set_blue
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // red_duty, green_duty, blue_duty,
                                       // red_now, green_now, blue_now, lit, pad
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
  localparam logic [2:0] REG_PERIOD_STEPS = 3'd1;
  localparam logic [2:0] REG_TARGET_RED   = 3'd2;
  localparam logic [2:0] REG_TARGET_GREEN = 3'd3;
  localparam logic [2:0] REG_TARGET_BLUE  = 3'd4;
  localparam logic [2:0] REG_COMMON_ANODE = 3'd5;

  localparam logic [15:0] PERIOD_RESET = 16'd100;

  // configuration registers
  logic [1:0]  mode_r;
  logic [15:0] period_r;
  logic [7:0]  tgt_red_r, tgt_green_r, tgt_blue_r;
  logic        anode_r;

  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rgbb_pkg::MODE_STATIC;
      period_r    <= PERIOD_RESET;
      tgt_red_r   <= '0;
      tgt_green_r <= '0;
      tgt_blue_r  <= '0;
      anode_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_EFFECT_MODE:  mode_r      <= cfg_pwdata[1:0];
        REG_PERIOD_STEPS: period_r    <= cfg_pwdata[15:0];
        REG_TARGET_RED:   tgt_red_r   <= cfg_pwdata[7:0];
        REG_TARGET_GREEN: tgt_green_r <= cfg_pwdata[7:0];
        REG_TARGET_BLUE:  tgt_blue_r  <= cfg_pwdata[7:0];
        REG_COMMON_ANODE: anode_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_EFFECT_MODE:  cfg_prdata = 32'(mode_r);
      REG_PERIOD_STEPS: cfg_prdata = 32'(period_r);
      REG_TARGET_RED:   cfg_prdata = 32'(tgt_red_r);
      REG_TARGET_GREEN: cfg_prdata = 32'(tgt_green_r);
      REG_TARGET_BLUE:  cfg_prdata = 32'(tgt_blue_r);
      REG_COMMON_ANODE: cfg_prdata = 32'(anode_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // engine
  rgbb_pkg::cfg_t eng_cfg;
  rgbb_pkg::req_t eng_req;
  rgbb_pkg::res_t eng_res;
  logic           eng_idle, eng_done, res_free, step_clr;

  assign eng_cfg.mode      = mode_r;
  assign eng_cfg.period    = period_r;
  assign eng_cfg.tgt_red   = tgt_red_r;
  assign eng_cfg.tgt_green = tgt_green_r;
  assign eng_cfg.tgt_blue  = tgt_blue_r;

  assign eng_req.kind  = in_tuser;
  assign eng_req.red   = in_tdata[7:0];
  assign eng_req.green = in_tdata[15:8];
  assign eng_req.blue  = in_tdata[23:16];

  assign step_clr  = cfg_wr && (cfg_idx == REG_PERIOD_STEPS);
  assign in_tready = eng_idle;
  assign res_free  = !out_tvalid || out_tready;

  rgbb_engine #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .STEP_BITS    (STEP_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (eng_cfg),
    .step_clr_i (step_clr),
    .start_i    (in_tvalid && in_tready),
    .req_i      (eng_req),
    .idle_o     (eng_idle),
    .res_free_i (res_free),
    .done_o     (eng_done),
    .res_o      (eng_res)
  );

  // level to duty: optional inversion, then 256/255 scaling
  function automatic logic [8:0] duty_of(input logic [7:0] level, input logic inv);
    logic [7:0] v;
    v = inv ? ~level : level;
    return {1'b0, v} + {8'd0, &v};
  endfunction

  // output register
  logic [55:0] out_data_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_data_r <= {4'd0, eng_res.lit, eng_res.blue, eng_res.green, eng_res.red,
                     duty_of(eng_res.blue, anode_r), duty_of(eng_res.green, anode_r),
                     duty_of(eng_res.red, anode_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### rtl/rgbb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  function automatic logic [8:0] duty_of(input logic [7:0] v);
    return {1'b0, v} + {8'd0, &v};
  endfunction

  logic [8:0] red_duty, green_duty, blue_duty;
  logic [7:0] red_now, green_now, blue_now;
  logic       duty_plain, duty_inv;

  assign red_duty   = out_tdata[8:0];
  assign green_duty = out_tdata[17:9];
  assign blue_duty  = out_tdata[26:18];
  assign red_now    = out_tdata[34:27];
  assign green_now  = out_tdata[42:35];
  assign blue_now   = out_tdata[50:43];

  assign duty_plain = (red_duty == duty_of(red_now)) &&
                      (green_duty == duty_of(green_now)) &&
                      (blue_duty == duty_of(blue_now));
  assign duty_inv   = (red_duty == duty_of(~red_now)) &&
                      (green_duty == duty_of(~green_now)) &&
                      (blue_duty == duty_of(~blue_now));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: ready drops after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while engine busy");

  // duties follow the held colour, all plain or all inverted
  a_duty_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> duty_plain || duty_inv)
    else $error("duty does not match held colour");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rgb_breathing_led_driver rgbb_checker u_rgbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### bench/tb_rgb_breathing_led_driver.sv
`timescale 1ns / 1ps

module tb_rgb_breathing_led_driver;

  localparam int TABLE_SIZE     = 256;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_AT     = 60;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PRINT_CAP      = 100;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;

  // register indexes
  localparam int REG_MODE   = 0;
  localparam int REG_PERIOD = 1;
  localparam int REG_RED    = 2;
  localparam int REG_GREEN  = 3;
  localparam int REG_BLUE   = 4;
  localparam int REG_ANODE  = 5;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [8:0] red_duty;
    logic [8:0] green_duty;
    logic [8:0] blue_duty;
    logic [7:0] red_now;
    logic [7:0] green_now;
    logic [7:0] blue_now;
    logic       lit;
  } led_result_t;

  // predicts the led levels and duties, holds the results still owed
  class led_duty_board;
    logic [1:0]  mode;
    logic [15:0] period;
    logic [7:0]  tgt_red, tgt_green, tgt_blue;
    logic        anode;
    logic [15:0] step;
    logic [7:0]  hold_red, hold_green, hold_blue;
    logic        lit_flag;
    int unsigned sine_q16[TABLE_SIZE];
    led_result_t pending_duties[$];
    int          errors;

    function new();
      mode      = rgbb_pkg::MODE_STATIC;
      period    = 16'd100;
      tgt_red   = 8'd0;
      tgt_green = 8'd0;
      tgt_blue  = 8'd0;
      anode     = 1'b0;
      step      = 16'd0;
      hold_red  = 8'd0;
      hold_green = 8'd0;
      hold_blue = 8'd0;
      lit_flag  = 1'b0;
      errors    = 0;
      for (int i = 0; i < TABLE_SIZE; i++) sine_q16[i] = quarter_sine(i);
    endfunction

    // odd polynomial sine in q30, rounded to q16
    function int unsigned quarter_sine(int unsigned idx);
      longint unsigned x, x2, t, v;
      x  = 64'(idx);
      x  = (x << 30) / TABLE_SIZE;
      x2 = (x * x) >> 30;
      t  = 64'd172272;
      t  = 64'd5026995 - ((x2 * t) >> 30);
      t  = 64'd85569306 - ((x2 * t) >> 30);
      t  = 64'd693598668 - ((x2 * t) >> 30);
      t  = 64'd1686629713 - ((x2 * t) >> 30);
      v  = (((x * t) >> 30) + 64'd8192) >> 14;
      return (v > 64'd65535) ? 65535 : int'(v);
    endfunction

    // (sin + 1) / 2 in q16 from the quarter-wave lookup
    function int unsigned brightness(longint unsigned s, longint unsigned per);
      longint unsigned p, q, i, mag;
      p = (s * 4 * TABLE_SIZE) / per;
      q = (p / TABLE_SIZE) & 3;
      i = p % TABLE_SIZE;
      if (q[0]) mag = (i == 0) ? 65536 : sine_q16[TABLE_SIZE - i];
      else mag = sine_q16[i];
      return q[1] ? int'((65536 - mag) >> 1) : int'((65536 + mag) >> 1);
    endfunction

    // one breathing tick: advance the step and recompute the held colour
    function void advance_breath();
      longint unsigned per, nxt, h, sector, f, w, c, x, r, g, b;
      int unsigned bq;
      per  = (period == 16'd0) ? 1 : 64'(period);
      nxt  = (64'(step) + 1) % per;
      step = nxt[15:0];
      bq   = brightness(nxt, per);
      if (mode == rgbb_pkg::MODE_MONO) begin
        hold_red   = 8'((32'(tgt_red) * bq) >> 16);
        hold_green = 8'((32'(tgt_green) * bq) >> 16);
        hold_blue  = 8'((32'(tgt_blue) * bq) >> 16);
      end else begin
        // six-sector hue sweep at full saturation
        h      = (nxt * 6 * 65536) / per;
        sector = h >> 16;
        f      = h & 64'hFFFF;
        w      = sector[0] ? 65536 - f : f;
        c      = (64'(bq) * 255) >> 16;
        x      = (64'(bq) * w * 255) >> 32;
        r = 0;
        g = 0;
        b = 0;
        case (sector)
          0: begin r = c; g = x; end
          1: begin r = x; g = c; end
          2: begin g = c; b = x; end
          3: begin g = x; b = c; end
          4: begin r = x; b = c; end
          default: begin r = c; b = x; end
        endcase
        hold_red   = r[7:0];
        hold_green = g[7:0];
        hold_blue  = b[7:0];
      end
    endfunction

    // inversion for common anode, then scale by 256/255
    function logic [8:0] to_duty(logic [7:0] lvl);
      int unsigned v;
      v = anode ? 255 - int'(lvl) : int'(lvl);
      return 9'((v * 256) / 255);
    endfunction

    function void apply_reg(int idx, logic [31:0] val);
      case (idx)
        REG_MODE:   mode = val[1:0];
        REG_PERIOD: begin
          period = val[15:0];
          step   = 16'd0;
        end
        REG_RED:    tgt_red = val[7:0];
        REG_GREEN:  tgt_green = val[7:0];
        REG_BLUE:   tgt_blue = val[7:0];
        REG_ANODE:  anode = val[0];
        default: ;
      endcase
    endfunction

    // accepted input transaction: update state and queue the expected duties
    function void note_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      led_result_t want;
      if (kind == rgbb_pkg::REQ_SET) begin
        hold_red   = r;
        hold_green = g;
        hold_blue  = b;
        lit_flag   = |{r, g, b};
      end else if (mode == rgbb_pkg::MODE_MONO || mode == rgbb_pkg::MODE_RAINBOW) begin
        advance_breath();
      end
      want.red_duty   = to_duty(hold_red);
      want.green_duty = to_duty(hold_green);
      want.blue_duty  = to_duty(hold_blue);
      want.red_now    = hold_red;
      want.green_now  = hold_green;
      want.blue_now   = hold_blue;
      want.lit        = lit_flag;
      pending_duties.push_back(want);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void compare_field(string name, logic [8:0] got, logic [8:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    // accepted result transaction: compare against the oldest expectation
    function void check_duties(logic [55:0] d);
      led_result_t want;
      if (pending_duties.size() == 0) begin
        report($sformatf("result %h with nothing expected", d));
        return;
      end
      want = pending_duties.pop_front();
      compare_field("red_duty", d[8:0], want.red_duty);
      compare_field("green_duty", d[17:9], want.green_duty);
      compare_field("blue_duty", d[26:18], want.blue_duty);
      compare_field("red_now", 9'(d[34:27]), 9'(want.red_now));
      compare_field("green_now", 9'(d[42:35]), 9'(want.green_now));
      compare_field("blue_now", 9'(d[50:43]), 9'(want.blue_now));
      compare_field("lit", 9'(d[51]), 9'(want.lit));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = 24'd0;   // set_red, set_green, set_blue
  logic        in_tuser = 1'b0;    // req_type
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [55:0] out_tdata;          // red_duty, green_duty, blue_duty,
                                   // red_now, green_now, blue_now, lit, pad
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  led_duty_board duty_board;
  bit            no_idle = 1'b0;
  int            received = 0;
  int            cycle_count = 0;

  rgb_breathing_led_driver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rgb_breathing_led_driver: done, errors");
      $finish;
    end
  end

  // offer one request transaction after a random gap
  task automatic offer_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    duty_board.note_request(kind, r, g, b);
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (duty_board.pending_duties.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup then access
  task automatic apb_write(int idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    duty_board.apply_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin : result_side
    int gap;
    bit did_holdoff;
    did_holdoff = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (!did_holdoff && received >= HOLDOFF_AT) begin
        gap = HOLDOFF_CYCLES;
        did_holdoff = 1'b1;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      duty_board.check_duties(out_tdata);
      received++;
    end
  end

  initial begin : stimulus
    logic [7:0] r, g, b;
    duty_board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // static mode: tick, black, white, alternating bit patterns
    offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    offer_request(rgbb_pkg::REQ_SET, 8'h00, 8'h00, 8'h00);
    offer_request(rgbb_pkg::REQ_SET, 8'hFF, 8'hFF, 8'hFF);
    offer_request(rgbb_pkg::REQ_SET, 8'h55, 8'hAA, 8'h01);
    offer_request(rgbb_pkg::REQ_SET, 8'hAA, 8'h55, 8'h80);
    offer_request(rgbb_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF);
    drain();

    // common anode inversion
    apb_write(REG_ANODE, 32'd1);
    offer_request(rgbb_pkg::REQ_SET, 8'hFF, 8'h00, 8'h80);
    offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    drain();
    apb_write(REG_ANODE, 32'd0);

    // mono breathing, set colour gets overwritten by the next tick, step wraps
    apb_write(REG_MODE, 32'(rgbb_pkg::MODE_MONO));
    apb_write(REG_PERIOD, 32'd4);
    apb_write(REG_RED, 32'd255);
    apb_write(REG_GREEN, 32'd128);
    apb_write(REG_BLUE, 32'd1);
    offer_request(rgbb_pkg::REQ_SET, 8'hFF, 8'h00, 8'h00);
    repeat (5) offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    drain();

    // rainbow through all six sectors
    apb_write(REG_MODE, 32'(rgbb_pkg::MODE_RAINBOW));
    apb_write(REG_PERIOD, 32'd6);
    repeat (6) offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    drain();

    // zero period acts as one
    apb_write(REG_PERIOD, 32'd0);
    repeat (2) offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    drain();

    // unused mode behaves as static
    apb_write(REG_MODE, 32'(MODE_UNUSED));
    offer_request(rgbb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00);
    offer_request(rgbb_pkg::REQ_SET, 8'h12, 8'h00, 8'hED);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apb_write(REG_MODE, 32'(rgbb_pkg::MODE_MONO));
        1: apb_write(REG_MODE, 32'(rgbb_pkg::MODE_RAINBOW));
        default: apb_write(REG_MODE, 32'($urandom_range(0, 2)));
      endcase
      case (ph)
        1: apb_write(REG_PERIOD, 32'd65535);
        2: apb_write(REG_PERIOD, 32'd1);
        3: apb_write(REG_PERIOD, 32'($urandom_range(1, 65535)));
        default: apb_write(REG_PERIOD, 32'($urandom_range(1, 48)));
      endcase
      case (ph)
        4: begin
          apb_write(REG_RED, 32'd255);
          apb_write(REG_GREEN, 32'd255);
          apb_write(REG_BLUE, 32'd255);
        end
        5: begin
          apb_write(REG_RED, 32'd0);
          apb_write(REG_GREEN, 32'd0);
          apb_write(REG_BLUE, 32'd0);
        end
        default: begin
          apb_write(REG_RED, 32'($urandom_range(0, 255)));
          apb_write(REG_GREEN, 32'($urandom_range(0, 255)));
          apb_write(REG_BLUE, 32'($urandom_range(0, 255)));
        end
      endcase
      apb_write(REG_ANODE, 32'(ph % 2));
      no_idle = (ph % 4 == 3);

      // mostly ticks, some set-colour transactions, a few of them black
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          r = 8'd0;
          g = 8'd0;
          b = 8'd0;
        end
        if ($urandom_range(0, 4) == 0) offer_request(rgbb_pkg::REQ_SET, r, g, b);
        else offer_request(rgbb_pkg::REQ_TICK, r, g, b);
      end
      drain();
    end

    no_idle = 1'b0;
    repeat (50) @(negedge clk);
    if (duty_board.errors == 0 && duty_board.pending_duties.size() == 0) begin
      $display("tb_rgb_breathing_led_driver: done, clean");
    end else begin
      $display("tb_rgb_breathing_led_driver: done, errors");
    end
    $finish;
  end

endmodule
